>>> src/ffba_pkg.sv
// Package for the first-fit block allocator: sizes, status codes, states.
// Used by ffba_seg_mem and first_fit_block_allocator.
package ffba_pkg;
  localparam int HeapBlocks = 1024;
  localparam int IdxW = 10;
  localparam int LenW = 10;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [LenW-1:0] len_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_SIZE = 2'd1,
    ST_NOFIT = 2'd2,
    ST_BADADDR = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_SPLIT,
    S_F_RD,
    S_F_CHK,
    S_F_WALK,
    S_F_NXRD,
    S_F_NXCHK,
    S_F_PVRD,
    S_F_PVCHK,
    S_CLEAR,
    S_DONE
  } state_t;

  // one segment table entry
  typedef struct packed {
    logic start;
    logic used;
    len_t len;
  } seg_t;

  // table access request
  typedef struct packed {
    logic we;
    idx_t waddr;
    seg_t wdata;
    idx_t raddr;
  } mem_req_t;
endpackage

>>> src/ffba_seg_mem.sv
// Segment table memory: one write and one registered read per cycle.
// Depends on ffba_pkg.
module ffba_seg_mem (
  input  logic              clk,
  input  ffba_pkg::mem_req_t req,
  output ffba_pkg::seg_t    rdata
);
  ffba_pkg::seg_t mem [ffba_pkg::HeapBlocks];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

>>> src/first_fit_block_allocator.sv
// First-fit block allocator with coalescing; the receiver cannot stall the result.
// A request walks the segment table one header at a time, a read state then a check
// state per header (single read port). Allocate strobes done once a fitting segment is
// written, after an extra write of the remainder on a split; free walks to the segment
// before it if any, merges with a free next and a free previous segment, then strobes done. A size
// error, data_block 0 or a bad header ends the request with its status. busy stays high
// through the strobe cycle. After rst the table is swept clear, one block a cycle (busy high).
module first_fit_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [15:0] size_blocks,
  input  logic [9:0]  data_block,
  output logic        done,
  output logic [1:0]  status,
  output logic [9:0]  granted_block,
  output logic [9:0]  granted_blocks
);
  localparam int CntW = ffba_pkg::IdxW + 1;
  localparam logic [CntW-1:0] HeapEnd = CntW'(ffba_pkg::HeapBlocks);

  ffba_pkg::state_t state, state_next;
  ffba_pkg::mem_req_t req;
  ffba_pkg::seg_t rd;

  logic [CntW-1:0] cur, cur_next;   // header being examined
  logic [CntW-1:0] prev, prev_next;
  logic have_prev, have_prev_next;
  logic [ffba_pkg::LenW-1:0] want, want_next;
  ffba_pkg::idx_t hdr, hdr_next;    // header of segment being freed
  ffba_pkg::seg_t hseg, hseg_next;  // its (updated) entry; on allocate, the split remainder
  logic [1:0] st, st_next;
  ffba_pkg::idx_t gb, gb_next;
  ffba_pkg::len_t gn, gn_next;
  logic [CntW-1:0] nxt;
  logic [CntW-1:0] ext;
  logic func_r;

  ffba_seg_mem u_mem (.clk(clk), .req(req), .rdata(rd));

  assign nxt = cur + CntW'(rd.len) + CntW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffba_pkg::S_CLEAR;
      cur <= '0;
    end else begin
      state <= state_next;
      cur <= cur_next;
    end
    prev <= prev_next;
    have_prev <= have_prev_next;
    want <= want_next;
    hdr <= hdr_next;
    hseg <= hseg_next;
    st <= st_next;
    gb <= gb_next;
    gn <= gn_next;
  end

  always_comb begin
    state_next = state;
    cur_next = cur;
    prev_next = prev;
    have_prev_next = have_prev;
    want_next = want;
    hdr_next = hdr;
    hseg_next = hseg;
    st_next = st;
    gb_next = gb;
    gn_next = gn;
    req = '0;
    req.raddr = cur[ffba_pkg::IdxW-1:0];
    ext = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      ffba_pkg::S_CLEAR: begin
        req.we = 1'b1;
        req.waddr = cur[ffba_pkg::IdxW-1:0];
        if (cur == '0) begin
          req.wdata = '{start: 1'b1, used: 1'b0,
                        len: ffba_pkg::LenW'(ffba_pkg::HeapBlocks - 1)};
        end
        cur_next = cur + CntW'(1);
        if (cur == HeapEnd - CntW'(1)) begin
          state_next = ffba_pkg::S_IDLE;
        end
      end
      ffba_pkg::S_IDLE: begin
        busy = 1'b0;
        st_next = ffba_pkg::ST_OK;
        gb_next = '0;
        gn_next = '0;
        cur_next = '0;
        prev_next = '0;
        have_prev_next = 1'b0;
        want_next = size_blocks[ffba_pkg::LenW-1:0];
        hdr_next = data_block - ffba_pkg::IdxW'(1);
        if (start) begin
          if (func == 1'b0) begin
            if (size_blocks == '0 || size_blocks > 16'(ffba_pkg::HeapBlocks - 1)) begin
              st_next = ffba_pkg::ST_SIZE;
              state_next = ffba_pkg::S_DONE;
            end else begin
              state_next = ffba_pkg::S_A_RD;
            end
          end else if (data_block == '0) begin
            st_next = ffba_pkg::ST_BADADDR;
            state_next = ffba_pkg::S_DONE;
          end else begin
            state_next = ffba_pkg::S_F_RD;
          end
        end
      end
      ffba_pkg::S_A_RD: begin
        state_next = ffba_pkg::S_A_CHK;
      end
      ffba_pkg::S_A_CHK: begin
        if (!rd.used && rd.len >= want) begin
          gb_next = ffba_pkg::IdxW'(cur + CntW'(1));
          req.we = 1'b1;
          req.waddr = cur[ffba_pkg::IdxW-1:0];
          req.wdata = '{start: 1'b1, used: 1'b1, len: rd.len};
          gn_next = rd.len;
          if (rd.len - want >= ffba_pkg::LenW'(2)) begin
            req.wdata.len = want;
            gn_next = want;
            hseg_next = '{start: 1'b1, used: 1'b0,
                          len: rd.len - want - ffba_pkg::LenW'(1)};
            state_next = ffba_pkg::S_A_SPLIT;
          end else begin
            state_next = ffba_pkg::S_DONE;
          end
        end else if (nxt >= HeapEnd) begin
          st_next = ffba_pkg::ST_NOFIT;
          state_next = ffba_pkg::S_DONE;
        end else begin
          cur_next = nxt;
          state_next = ffba_pkg::S_A_RD;
        end
      end
      ffba_pkg::S_A_SPLIT: begin
        req.we = 1'b1;
        req.waddr = gb + want;
        req.wdata = hseg;
        state_next = ffba_pkg::S_DONE;
      end
      ffba_pkg::S_F_RD: begin
        req.raddr = hdr;
        state_next = ffba_pkg::S_F_CHK;
      end
      ffba_pkg::S_F_CHK: begin
        if (!rd.start || !rd.used) begin
          st_next = ffba_pkg::ST_BADADDR;
          state_next = ffba_pkg::S_DONE;
        end else begin
          hseg_next = '{start: 1'b1, used: 1'b0, len: rd.len};
          cur_next = '0;
          state_next = (hdr == '0) ? ffba_pkg::S_F_NXRD : ffba_pkg::S_F_WALK;
        end
      end
      ffba_pkg::S_F_WALK: begin
        // issue the read of the entry at cur; rd holds it in S_F_PVRD (cur < hdr)
        state_next = ffba_pkg::S_F_PVRD;
      end
      ffba_pkg::S_F_PVRD: begin
        prev_next = cur;
        have_prev_next = 1'b1;
        if (nxt >= CntW'(hdr)) begin
          hseg_next.start = rd.used;  // remember prev in-use flag
          gn_next = rd.len;           // prev length
          cur_next = CntW'(hdr);
          state_next = ffba_pkg::S_F_NXRD;
        end else begin
          cur_next = nxt;
          state_next = ffba_pkg::S_F_WALK;
        end
      end
      ffba_pkg::S_F_NXRD: begin
        cur_next = CntW'(hdr) + CntW'(hseg.len) + CntW'(1);
        req.raddr = ffba_pkg::IdxW'(CntW'(hdr) + CntW'(hseg.len) + CntW'(1));
        state_next = ffba_pkg::S_F_NXCHK;
      end
      ffba_pkg::S_F_NXCHK: begin
        ext = CntW'(hseg.len);
        if (cur < HeapEnd && rd.start && !rd.used) begin
          ext = CntW'(hseg.len) + CntW'(rd.len) + CntW'(1);
          req.we = 1'b1;
          req.waddr = cur[ffba_pkg::IdxW-1:0];
          req.wdata = '0;
        end
        hseg_next.len = ext[ffba_pkg::LenW-1:0];
        state_next = ffba_pkg::S_F_PVCHK;
      end
      ffba_pkg::S_F_PVCHK: begin
        req.we = 1'b1;
        if (have_prev && !hseg.start) begin
          req.waddr = prev[ffba_pkg::IdxW-1:0];
          req.wdata = '{start: 1'b1, used: 1'b0,
                        len: gn + hseg.len + ffba_pkg::LenW'(1)};
          // second write: clear the freed header
          hseg_next = '0;
          gn_next = '0;
          gb_next = hdr;
          want_next = '0;
          state_next = ffba_pkg::S_A_SPLIT;
        end else begin
          req.waddr = hdr;
          req.wdata = '{start: 1'b1, used: 1'b0, len: hseg.len};
          gn_next = '0;
          state_next = ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_DONE: begin
        done = 1'b1;
        if (func_r) begin
          gb_next = '0;
        end
        state_next = ffba_pkg::S_IDLE;
      end
      default: state_next = ffba_pkg::S_IDLE;
    endcase
  end

  // a free reuses the split write to clear its header; hseg is zero then
  always_ff @(posedge clk) begin
    if (state == ffba_pkg::S_IDLE && start) begin
      func_r <= func;
    end
  end

  assign status = st;
  assign granted_block = func_r ? '0 : gb;
  assign granted_blocks = func_r ? '0 : gn;
endmodule
